FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the wall-follow steering block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Antecedent implies consequent on the same edge.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lwf_pkg.sv
// ----------------------------------------------------------------------------
// lwf_pkg
// Types, fixed-point constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package lwf_pkg;

  localparam int CXW = 36;   // CORDIC x/y width
  localparam int CZW = 34;   // CORDIC angle width, Q29

  localparam logic signed [CXW-1:0] GAIN_Q30    = 36'sd652032874;
  localparam logic signed [CZW-1:0] PI_Q29      = 34'sd1686629713;
  localparam logic signed [CZW-1:0] HALF_PI_Q29 = 34'sd843314857;

  localparam logic signed [12:0] STEER_LIMIT    = 13'sd3574;
  localparam logic        [12:0] TEN_DEG_Q13    = 13'd1429;
  localparam logic        [12:0] TWENTY_DEG_Q13 = 13'd2859;

  localparam logic [1:0] SPEED_FAST = 2'd3;
  localparam logic [1:0] SPEED_MID  = 2'd2;
  localparam logic [1:0] SPEED_SLOW = 2'd1;

  typedef enum logic [2:0] {
    CFG_LOW_IDX  = 3'd0,
    CFG_HIGH_IDX = 3'd1,
    CFG_GAP      = 3'd2,
    CFG_TARGET   = 3'd3,
    CFG_LOOKAHD  = 3'd4,
    CFG_KP       = 3'd5,
    CFG_KD       = 3'd6,
    CFG_SUBST    = 3'd7
  } cfg_idx_t;

  typedef enum logic {
    CM_ROTATE = 1'b0,
    CM_VECTOR = 1'b1
  } cordic_mode_t;

  typedef struct packed {
    logic         start;
    cordic_mode_t mode;
  } cordic_ctrl_t;

  function automatic logic signed [CZW-1:0] atan_q29(input logic [4:0] i);
    logic signed [CZW-1:0] v;
    case (i)
      5'd0:  v = 34'sd421657428;
      5'd1:  v = 34'sd248918915;
      5'd2:  v = 34'sd131521918;
      5'd3:  v = 34'sd66762579;
      5'd4:  v = 34'sd33510843;
      5'd5:  v = 34'sd16771758;
      5'd6:  v = 34'sd8387925;
      5'd7:  v = 34'sd4194219;
      5'd8:  v = 34'sd2097141;
      5'd9:  v = 34'sd1048575;
      5'd10: v = 34'sd524288;
      5'd11: v = 34'sd262144;
      5'd12: v = 34'sd131072;
      5'd13: v = 34'sd65536;
      5'd14: v = 34'sd32768;
      5'd15: v = 34'sd16384;
      5'd16: v = 34'sd8192;
      5'd17: v = 34'sd4096;
      5'd18: v = 34'sd2048;
      5'd19: v = 34'sd1024;
      5'd20: v = 34'sd512;
      5'd21: v = 34'sd256;
      5'd22: v = 34'sd128;
      5'd23: v = 34'sd64;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/lwf_if.sv
// ----------------------------------------------------------------------------
// lwf_sample_if / lwf_result_if
// Valid/ready channels for range samples and steering results.
// ----------------------------------------------------------------------------
`default_nettype none

interface lwf_sample_if;
  logic        valid;
  logic        ready;
  logic [15:0] range_sample;
  logic        sample_invalid;
  logic        scan_end;
  modport source (output valid, range_sample, sample_invalid, scan_end, input ready);
  modport sink   (input valid, range_sample, sample_invalid, scan_end, output ready);
endinterface

interface lwf_result_if;
  logic               valid;
  logic               ready;
  logic signed [12:0] steer_cmd;
  logic        [1:0]  speed_code;
  logic signed [16:0] tracking_error;
  logic               beam_missing;
  modport source (output valid, steer_cmd, speed_code, tracking_error, beam_missing,
                  input ready);
  modport sink   (input valid, steer_cmd, speed_code, tracking_error, beam_missing,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/lwf_cordic.sv
// ----------------------------------------------------------------------------
// lwf_cordic
// Iterative CORDIC, one micro-rotation per cycle; rotation and vectoring.
// ----------------------------------------------------------------------------
`default_nettype none

module lwf_cordic #(
  parameter int STEPS = 16
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire lwf_pkg::cordic_ctrl_t       ctrl,
  input  wire logic signed [lwf_pkg::CXW-1:0] xin,
  input  wire logic signed [lwf_pkg::CXW-1:0] yin,
  input  wire logic signed [lwf_pkg::CZW-1:0] zin,
  output logic                             done,
  output logic signed [lwf_pkg::CXW-1:0]   xo,
  output logic signed [lwf_pkg::CXW-1:0]   yo,
  output logic signed [lwf_pkg::CZW-1:0]   zo
);
  import lwf_pkg::*;

  localparam int IW = $clog2(STEPS);

  logic signed [CXW-1:0] x, y;
  logic signed [CZW-1:0] z;
  logic                  flip, zero, busy;
  cordic_mode_t          mode;
  logic [IW-1:0]         cnt;

  logic                  dir;
  logic signed [CZW-1:0] at;

  always_comb begin
    at  = atan_q29(5'(cnt));
    dir = (mode == CM_ROTATE) ? (z >= 0) : !(y > 0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        mode <= ctrl.mode;
        flip <= 1'b0;
        zero <= 1'b0;
        if (ctrl.mode == CM_ROTATE) begin
          x <= GAIN_Q30;
          y <= '0;
          if (zin > HALF_PI_Q29) begin
            z    <= zin - PI_Q29;
            flip <= 1'b1;
          end else if (zin < -HALF_PI_Q29) begin
            z    <= zin + PI_Q29;
            flip <= 1'b1;
          end else begin
            z <= zin;
          end
        end else begin
          zero <= (xin == 0) && (yin == 0);
          if (xin < 0) begin
            x <= -xin;
            y <= -yin;
            z <= (yin >= 0) ? PI_Q29 : -PI_Q29;
          end else begin
            x <= xin;
            y <= yin;
            z <= '0;
          end
        end
      end else if (busy) begin
        if (dir) begin
          x <= x - (y >>> cnt);
          y <= y + (x >>> cnt);
          z <= z - at;
        end else begin
          x <= x + (y >>> cnt);
          y <= y - (x >>> cnt);
          z <= z + at;
        end
        if (cnt == IW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  // vectoring mode: x unchanged direction sign, dir picks add when y <= 0
  assign xo = flip ? -x : x;
  assign yo = flip ? -y : y;
  assign zo = zero ? '0 : z;

endmodule

`default_nettype wire

FILE: rtl/lidar_wall_follow_pd_steer_unit.sv
// ----------------------------------------------------------------------------
// lidar_wall_follow_pd_steer_unit
// Two-beam wall-following PD steering over one lidar scan.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  samples   in   valid/ready   range_sample, sample_invalid, scan_end
//  result    out  valid/ready   steer_cmd, speed_code, tracking_error,
//                               beam_missing
//  cfg       in   cfg_write     cfg_index, cfg_data
//
//  A sample that does not end a scan leaves the unit idle for the next one.
//  A scan end with both beams makes three passes of the shared CORDIC plus
//  six passes of the shared multiplier.
//  samples.ready is low while a scan end is processed or a result waits.
//  Reset is synchronous; config registers return to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lidar_wall_follow_pd_steer_unit #(
  parameter int SCAN_BEAMS   = 1024,
  parameter int CORDIC_STEPS = 16
) (
  input  wire         clk,
  input  wire         rst,
  lwf_sample_if.sink  samples,
  lwf_result_if.source result,
  input  wire         cfg_write,
  input  wire  [2:0]  cfg_index,
  input  wire  [15:0] cfg_data
);
  import lwf_pkg::*;

  localparam int BW = $clog2(SCAN_BEAMS);
  localparam int XW = (BW > 10) ? BW : 10;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CS, ST_M1, ST_M2, ST_ND, ST_AT, ST_CA,
    ST_M3, ST_M4, ST_ERR, ST_M5, ST_M6, ST_STEER
  } state_t;

  state_t state;

  logic [9:0]  low_idx, high_idx;
  logic [14:0] gap;
  logic [15:0] target, lookahd, kp, kd, subst;

  logic [BW-1:0]      beam_counter;
  logic [15:0]        low_hold, high_hold;
  logic               low_cap, high_cap;
  logic signed [16:0] prev_err, err;

  logic signed [18:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [50:0] prod, hold;

  cordic_ctrl_t          cctrl;
  logic signed [CXW-1:0] cxin, cyin, cxo, cyo;
  logic signed [CZW-1:0] czin, czo;
  logic                  cdone;

  logic        out_valid;
  logic [15:0] r;
  logic        acc, low_hit, high_hit;

  logic signed [21:0] num, den;
  logic signed [21:0] proj_dist;
  logic signed [22:0] err_full;
  logic signed [51:0] steer_sum;
  logic signed [46:0] steer_sh;
  logic signed [12:0] steer;
  logic        [12:0] mag;

  lwf_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .ctrl(cctrl), .xin(cxin), .yin(cyin), .zin(czin),
    .done(cdone), .xo(cxo), .yo(cyo), .zo(czo)
  );

  assign samples.ready = (state == ST_IDLE) && !out_valid;
  assign acc           = samples.valid && samples.ready;
  assign r             = samples.sample_invalid ? subst : samples.range_sample;
  assign low_hit       = XW'(beam_counter) == XW'(low_idx);
  assign high_hit      = XW'(beam_counter) == XW'(high_idx);

  always_comb begin
    num       = $signed({6'd0, high_hold}) - 22'($signed(hold[50:30]));
    den       = 22'($signed(prod[50:30])) + 22'sd1;
    proj_dist = 22'($signed(hold[50:30])) - 22'($signed(prod[50:30]));
    err_full  = $signed({7'd0, target}) - 23'(proj_dist);
    steer_sum = -52'(hold) - 52'(prod);
    steer_sh  = steer_sum[51:5];
    if (steer_sh > 47'(STEER_LIMIT))       steer = STEER_LIMIT;
    else if (steer_sh < -47'(STEER_LIMIT)) steer = -STEER_LIMIT;
    else                                   steer = steer_sh[12:0];
    mag = steer[12] ? 13'(-steer) : 13'(steer);
  end

  always_comb begin
    cctrl = '{start: 1'b0, mode: CM_ROTATE};
    cxin  = '0;
    cyin  = '0;
    czin  = CZW'($signed({1'b0, gap, 16'd0}));
    unique case (state)
      ST_IDLE: cctrl.start = acc && samples.scan_end
                             && (low_cap || low_hit) && (high_cap || high_hit);
      ST_ND: begin
        cctrl = '{start: 1'b1, mode: CM_VECTOR};
        cxin  = CXW'($signed({den, 12'd0}));
        cyin  = CXW'($signed({num, 12'd0}));
      end
      ST_AT: begin
        cctrl.start = cdone;
        czin        = czo;
      end
      default: ;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_M1: begin mul_a = $signed({3'd0, low_hold});  mul_b = cxo[31:0]; end
      ST_M2: begin mul_a = $signed({3'd0, low_hold});  mul_b = cyo[31:0]; end
      ST_M3: begin mul_a = $signed({3'd0, high_hold}); mul_b = cxo[31:0]; end
      ST_M4: begin mul_a = $signed({3'd0, lookahd});   mul_b = cyo[31:0]; end
      ST_M5: begin mul_a = 19'(err);                   mul_b = $signed({16'd0, kp}); end
      ST_M6: begin
        mul_a = 19'(err) - 19'(prev_err);
        mul_b = $signed({16'd0, kd});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      low_idx  <= '0;
      high_idx <= '0;
      gap      <= 15'd8579;
      target   <= 16'd819;
      lookahd  <= 16'd1536;
      kp       <= 16'd128;
      kd       <= 16'd1280;
      subst    <= 16'd30720;
    end else if (cfg_write) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LOW_IDX:  low_idx  <= cfg_data[9:0];
        CFG_HIGH_IDX: high_idx <= cfg_data[9:0];
        CFG_GAP:      gap      <= cfg_data[14:0];
        CFG_TARGET:   target   <= cfg_data;
        CFG_LOOKAHD:  lookahd  <= cfg_data;
        CFG_KP:       kp       <= cfg_data;
        CFG_KD:       kd       <= cfg_data;
        CFG_SUBST:    subst    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      beam_counter <= '0;
      low_hold     <= '0;
      high_hold    <= '0;
      low_cap      <= 1'b0;
      high_cap     <= 1'b0;
      prev_err     <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (result.valid && result.ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: if (acc) begin
          if (low_hit)  begin low_hold  <= r; low_cap  <= 1'b1; end
          if (high_hit) begin high_hold <= r; high_cap <= 1'b1; end
          beam_counter <= (beam_counter == BW'(SCAN_BEAMS - 1)) ? '0 : beam_counter + 1'b1;
          if (samples.scan_end) begin
            beam_counter <= '0;
            low_cap      <= 1'b0;
            high_cap     <= 1'b0;
            if ((low_cap || low_hit) && (high_cap || high_hit)) begin
              state <= ST_CS;
            end else begin
              out_valid             <= 1'b1;
              result.steer_cmd      <= '0;
              result.speed_code     <= SPEED_FAST;
              result.tracking_error <= '0;
              result.beam_missing   <= 1'b1;
            end
          end
        end
        ST_CS: if (cdone) state <= ST_M1;
        ST_M1: state <= ST_M2;
        ST_M2: begin hold <= prod; state <= ST_ND; end
        ST_ND: state <= ST_AT;
        ST_AT: if (cdone) state <= ST_CA;
        ST_CA: if (cdone) state <= ST_M3;
        ST_M3: state <= ST_M4;
        ST_M4: begin hold <= prod; state <= ST_ERR; end
        ST_ERR: begin
          if (err_full > 23'sd65535)       err <= 17'sd65535;
          else if (err_full < -23'sd65536) err <= -17'sd65536;
          else                             err <= err_full[16:0];
          state <= ST_M5;
        end
        ST_M5: state <= ST_M6;
        ST_M6: begin hold <= prod; state <= ST_STEER; end
        ST_STEER: begin
          prev_err              <= err;
          out_valid             <= 1'b1;
          result.steer_cmd      <= steer;
          result.speed_code     <= (mag <= TEN_DEG_Q13) ? SPEED_FAST :
                                   (mag <= TWENTY_DEG_Q13) ? SPEED_MID : SPEED_SLOW;
          result.tracking_error <= err;
          result.beam_missing   <= 1'b0;
          state                 <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign result.valid = out_valid;

  `ASSERT_IMPL(a_ready_no_pending, clk, rst, samples.ready, !result.valid, "ready with result pending")
  `ASSERT_IMPL(a_missing_vals, clk, rst, result.valid && result.beam_missing, result.steer_cmd == 0 && result.speed_code == SPEED_FAST && result.tracking_error == 0, "bad missing-beam result")
  `ASSERT_IMPL(a_steer_range, clk, rst, result.valid, result.steer_cmd <= STEER_LIMIT && result.steer_cmd >= -STEER_LIMIT, "steering out of range")
  `ASSERT_IMPL(a_cordic_idle_start, clk, rst, cctrl.start, state == ST_IDLE || state == ST_ND || state == ST_AT, "CORDIC started out of sequence")

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for the two-beam wall-following PD steering unit. Streams lidar
// scans through the sample channel over several register settings. A local
// model predicts each steering result, and results are checked in order,
// with random idle cycles on both channels and one long result back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import lwf_pkg::*;

  typedef struct packed {
    logic [15:0] range_mm;
    logic        invalid;
    logic        last;
  } sample_t;

  typedef struct packed {
    logic signed [12:0] steer;
    logic        [1:0]  speed;
    logic signed [16:0] err;
    logic               missing;
  } steer_result_t;

  localparam int LATENCY = 3 * 16 + 12 + 20;
  localparam int WATCHDOG_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  lwf_sample_if samples ();
  lwf_result_if result ();

  lidar_wall_follow_pd_steer_unit dut (
    .clk(clk), .rst(rst), .samples(samples.sink), .result(result.source),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  sample_t       scan_q[$];
  steer_result_t steer_q[$];
  bit            failed = 1'b0;
  int            cyc = 0;
  int            results_seen = 0;

  // model copy of registers and state
  longint lo_idx, hi_idx, gap, target, lookahead, kp, kd, subst;
  logic [9:0]  beam_cnt;
  longint lo_hold, hi_hold, prev_err;
  bit lo_got, hi_got;

  function automatic void rotate_q30(input longint ang, output longint c, output longint s);
    longint x, y, t;
    bit flip;
    x = longint'(GAIN_Q30);
    y = 0;
    flip = 1'b0;
    if (ang > longint'(HALF_PI_Q29)) begin
      ang -= longint'(PI_Q29);
      flip = 1'b1;
    end else if (ang < -longint'(HALF_PI_Q29)) begin
      ang += longint'(PI_Q29);
      flip = 1'b1;
    end
    for (int i = 0; i < 16; i++) begin
      t = x;
      if (ang >= 0) begin
        x -= y >>> i; y += t >>> i; ang -= longint'(atan_q29(i[4:0]));
      end else begin
        x += y >>> i; y -= t >>> i; ang += longint'(atan_q29(i[4:0]));
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint vector_atan2(input longint y, input longint x);
    longint z, t;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? longint'(PI_Q29) : -longint'(PI_Q29);
      x = -x; y = -y;
    end
    for (int i = 0; i < 16; i++) begin
      t = x;
      if (y > 0) begin
        x += y >>> i; y -= t >>> i; z += longint'(atan_q29(i[4:0]));
      end else begin
        x -= y >>> i; y += t >>> i; z -= longint'(atan_q29(i[4:0]));
      end
    end
    return z;
  endfunction

  function automatic void predict_steering(input sample_t s);
    longint r, ct, st, ca, sa, num, den, alpha, proj, err, steer, mag;
    steer_result_t res;
    r = s.invalid ? subst : longint'(s.range_mm);
    if (longint'(beam_cnt) == lo_idx) begin lo_hold = r; lo_got = 1'b1; end
    if (longint'(beam_cnt) == hi_idx) begin hi_hold = r; hi_got = 1'b1; end
    beam_cnt = beam_cnt + 10'd1;
    if (!s.last) return;
    if (!(lo_got && hi_got)) begin
      res = '{steer: '0, speed: SPEED_FAST, err: '0, missing: 1'b1};
    end else begin
      rotate_q30(gap * 65536, ct, st);
      num = hi_hold - ((lo_hold * ct) >>> 30);
      den = ((lo_hold * st) >>> 30) + 1;
      alpha = vector_atan2(num * 4096, den * 4096);
      rotate_q30(alpha, ca, sa);
      proj = ((hi_hold * ca) >>> 30) - ((lookahead * sa) >>> 30);
      err = target - proj;
      if (err > 65535) err = 65535;
      if (err < -65536) err = -65536;
      steer = (-(kp * err) - kd * (err - prev_err)) >>> 5;
      if (steer > 3574) steer = 3574;
      if (steer < -3574) steer = -3574;
      mag = steer < 0 ? -steer : steer;
      res.steer = steer[12:0];
      res.speed = mag <= longint'(TEN_DEG_Q13) ? SPEED_FAST :
                  (mag <= longint'(TWENTY_DEG_Q13) ? SPEED_MID : SPEED_SLOW);
      res.err = err[16:0];
      res.missing = 1'b0;
      prev_err = err;
    end
    steer_q.push_back(res);
    beam_cnt = '0;
    lo_got = 1'b0;
    hi_got = 1'b0;
  endfunction

  // sample driver
  always @(posedge clk) begin
    if (rst) begin
      samples.valid <= 1'b0;
      samples.range_sample <= '0;
      samples.sample_invalid <= 1'b0;
      samples.scan_end <= 1'b0;
    end else begin
      if (samples.valid && samples.ready) predict_steering({samples.range_sample,
          samples.sample_invalid, samples.scan_end});
      if (!samples.valid || samples.ready) begin
        if (scan_q.size() > 0 && ((cyc > 4000 && cyc < 7000) || $urandom_range(99) >= 22))
        begin
          {samples.range_sample, samples.sample_invalid, samples.scan_end} <=
              scan_q.pop_front();
          samples.valid <= 1'b1;
        end else begin
          samples.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      failed = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    steer_result_t want;
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        results_seen++;
        if (steer_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual steer %0d", $time,
                   result.steer_cmd);
          failed = 1'b1;
        end else begin
          want = steer_q.pop_front();
          check_field("steer_cmd", longint'($signed(want.steer)), result.steer_cmd);
          check_field("speed_code", want.speed, result.speed_code);
          check_field("tracking_error", longint'($signed(want.err)), result.tracking_error);
          check_field("beam_missing", want.missing, result.beam_missing);
        end
      end
      if (!hold_done && results_seen == 12) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        result.ready <= 1'b0;
      end else begin
        result.ready <= (cyc > 4000 && cyc < 7000) || $urandom_range(99) >= 22;
      end
    end
  end

  // watchdog on cycles without any transfer
  int quiet = 0;
  always @(posedge clk) begin
    cyc++;
    if (rst || (samples.valid && samples.ready) || (result.valid && result.ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic add_sample(input int r, input bit inv, input bit last);
    scan_q.push_back('{range_mm: r[15:0], invalid: inv, last: last});
  endtask

  task automatic drain();
    while (scan_q.size() > 0 || samples.valid || steer_q.size() > 0) @(negedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic program_regs(input longint v[8]);
    for (int i = 0; i < 8; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_data <= v[i][15:0];
      case (cfg_idx_t'(i))
        CFG_LOW_IDX:  lo_idx = v[i] & 10'h3FF;
        CFG_HIGH_IDX: hi_idx = v[i] & 10'h3FF;
        CFG_GAP:      gap = v[i] & 15'h7FFF;
        CFG_TARGET:   target = v[i] & 16'hFFFF;
        CFG_LOOKAHD:  lookahead = v[i] & 16'hFFFF;
        CFG_KP:       kp = v[i] & 16'hFFFF;
        CFG_KD:       kd = v[i] & 16'hFFFF;
        CFG_SUBST:    subst = v[i] & 16'hFFFF;
      endcase
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_scan(input int reach);
    int n;
    n = ($urandom_range(99) < 80) ? reach + $urandom_range(1, 8) : $urandom_range(1, 25);
    for (int i = 0; i < n; i++)
      add_sample(($urandom_range(99) < 70) ? $urandom_range(200, 8000) : $urandom_range(65535),
                 $urandom_range(99) < 10, i == n - 1);
  endtask

  initial begin
    longint v[8];
    int reach;
    lo_idx = 0; hi_idx = 0; gap = 8579; target = 819; lookahead = 1536;
    kp = 128; kd = 1280; subst = 30720;
    beam_cnt = '0; lo_hold = 0; hi_hold = 0; prev_err = 0;
    lo_got = 1'b0; hi_got = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // defaults: both beams at index 0, four one-sample scans and one two-sample scan
    add_sample(0, 0, 1);
    add_sample(65535, 0, 1);
    add_sample(123, 1, 1);
    add_sample(65535, 1, 1);
    add_sample(1000, 0, 0);
    add_sample(900, 0, 1);
    drain();

    // gap above pi, zero substitute, reversed indices, missing beam
    v = '{3, 1, 25736, 65535, 0, 65535, 65535, 0};
    program_regs(v);
    for (int i = 0; i < 5; i++) add_sample(500 * i + 300, i == 3, i == 4);
    add_sample(700, 0, 0);
    add_sample(800, 0, 1);
    for (int i = 0; i < 4; i++) add_sample(i == 1 ? 0 : 65535, i == 3, i == 3);
    drain();

    v = '{0, 0, 0, 0, 65535, 0, 0, 65535};
    program_regs(v);
    add_sample(0, 0, 1);
    add_sample(4000, 1, 1);
    drain();

    // random phases
    for (int p = 0; p < 9; p++) begin
      v[CFG_LOW_IDX] = $urandom_range(0, 20);
      v[CFG_HIGH_IDX] = $urandom_range(0, 20);
      case ($urandom_range(3))
        0: for (int i = 2; i < 8; i++) v[i] = $urandom_range(65535);
        1: begin
          v[2] = $urandom_range(4000, 12000);
          v[3] = $urandom_range(200, 3000);
          v[4] = $urandom_range(500, 4000);
          v[5] = $urandom_range(0, 1024);
          v[6] = $urandom_range(0, 4096);
          v[7] = $urandom_range(65535);
        end
        2: for (int i = 2; i < 8; i++) v[i] = (i == 2) ? 25736 : 65535;
        default: for (int i = 2; i < 8; i++) v[i] = 0;
      endcase
      if (v[CFG_GAP] > 25736) v[CFG_GAP] = $urandom_range(25736);
      program_regs(v);
      reach = int'(lo_idx > hi_idx ? lo_idx : hi_idx);
      while (scan_q.size() < 50) random_scan(reach);
      drain();
    end

    // long scan: counter wraps, top index reached, low index beyond one scan length
    v = '{1023, 2, 6000, 1000, 1536, 300, 900, 30720};
    program_regs(v);
    for (int i = 0; i < 1030; i++)
      add_sample($urandom_range(65535), $urandom_range(99) < 10, i == 1029);
    add_sample(100, 0, 0);
    add_sample(200, 0, 1);
    drain();

    if (!failed) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
